FILE: hw/rtl/lfrd_pkg.sv
`default_nettype none

package lfrd_pkg;

   // Generator geometry.
   localparam int RING_DEPTH = 55;
   localparam int SHORT_LAG  = 24;
   localparam int TAP_START  = RING_DEPTH - SHORT_LAG;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int WORD_W     = 30;
   localparam int OUT_SHIFT  = 6;
   localparam int GEN_W      = WORD_W - OUT_SHIFT;
   localparam int DATA_W     = 32;

   // Rejection sampling gives up after this many generator outputs.
   localparam int MAX_TRIES  = 4096;
   localparam int TRY_W      = $clog2(MAX_TRIES);

   // Request kinds.
   localparam logic KIND_RESEED = 1'b0;
   localparam logic KIND_DRAW   = 1'b1;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FILL  = 5'b00010,
      ST_SETUP = 5'b00100,
      ST_STEP  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // Ring write port.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [WORD_W-1:0] data;
   } ring_wr_type;

   // Ring read addresses, one per read port.
   typedef struct packed {
      logic [IDX_W-1:0] addr_a;
      logic [IDX_W-1:0] addr_b;
   } ring_rd_type;

   // Advance a ring index with wrap at the ring depth.
   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      if (idx == IDX_W'(RING_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + IDX_W'(1);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lfrd_ring.sv
`default_nettype none

module lfrd_ring (
   input  wire                          clock,
   input  wire                          reset,
   input  wire lfrd_pkg::ring_wr_type   wr,
   input  wire lfrd_pkg::ring_rd_type   rd,
   output logic [lfrd_pkg::WORD_W-1:0]  rd_data_a,
   output logic [lfrd_pkg::WORD_W-1:0]  rd_data_b
);
   import lfrd_pkg::*;

   logic [WORD_W-1:0]     mem_ff [RING_DEPTH];
   logic [RING_DEPTH-1:0] valid_ff;
   logic [WORD_W-1:0]     rd_a_ff;
   logic [WORD_W-1:0]     rd_b_ff;

   // Storage write.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Per-entry valid flags; an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // Two registered read ports.
   always_ff @(posedge clock) begin
      rd_a_ff <= valid_ff[rd.addr_a] ? mem_ff[rd.addr_a] : '0;
      rd_b_ff <= valid_ff[rd.addr_b] ? mem_ff[rd.addr_b] : '0;
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lagged_fibonacci_range_draw.sv
// Draw: a setup state (SETUP), then generator steps (STEP) until a hit or the try limit;
// an empty or single span takes the low bound from SETUP; a stalled output waits in EMIT.
// The input stalls until a draw is done, so no new draw is taken before the last is through.
// Reseed: one ring entry written per cycle, no result.
// Reset: the ring reads as zero through per-entry valid flags; write index 0, tap index 31.
`default_nettype none

module lagged_fibonacci_range_draw (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_kind,
   input  wire [lfrd_pkg::WORD_W-1:0]   req_seed_value,
   input  wire signed [lfrd_pkg::DATA_W-1:0] req_range_low,
   input  wire signed [lfrd_pkg::DATA_W-1:0] req_range_high,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic signed [lfrd_pkg::DATA_W-1:0] rsp_drawn_value
);
   import lfrd_pkg::*;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  w_ff, w_in;
   logic [IDX_W-1:0]  t_ff, t_in;
   logic [IDX_W-1:0]  fill_idx_ff, fill_idx_in;
   logic [WORD_W-1:0] prev1_ff, prev1_in;
   logic [WORD_W-1:0] prev2_ff, prev2_in;
   logic [WORD_W-1:0] seed_ff, seed_in;
   logic [DATA_W-1:0] lo_ff, lo_in;
   logic [DATA_W-1:0] hi_ff, hi_in;
   logic [DATA_W-1:0] diff_ff, diff_in;
   logic [DATA_W-1:0] mask_ff, mask_in;
   logic [TRY_W-1:0]  try_ff, try_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;

   ring_wr_type       ring_wr;
   ring_rd_type       ring_rd;
   logic [WORD_W-1:0] rd_a;
   logic [WORD_W-1:0] rd_b;

   logic              req_xfer;
   logic              out_free;
   logic              out_load;
   logic [DATA_W-1:0] out_data;
   logic [WORD_W-1:0] fill_word;
   logic [DATA_W:0]   diff_wide;
   logic              span_single;
   logic [DATA_W-1:0] smear;
   logic [WORD_W-1:0] gen_sum;
   logic [DATA_W-1:0] number;
   logic              hit;
   logic              last_try;
   logic [DATA_W-1:0] half;
   logic [DATA_W-1:0] pick;
   logic [DATA_W-1:0] draw_value;
   logic [IDX_W:0]    tap_sum;
   logic [IDX_W-1:0]  tap_expect;

   // Lag ring storage.
   lfrd_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .wr        (ring_wr),
      .rd        (ring_rd),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Reseed word: seed, then one, then the sum of the two before.
   always_comb begin
      if (fill_idx_ff == IDX_W'(0)) begin
         fill_word = seed_ff;
      end else if (fill_idx_ff == IDX_W'(1)) begin
         fill_word = WORD_W'(1);
      end else begin
         fill_word = prev1_ff + prev2_ff;
      end
   end

   // Span minus one and the covering power-of-two mask.
   always_comb begin
      diff_wide   = {hi_ff[DATA_W-1], hi_ff} - {lo_ff[DATA_W-1], lo_ff};
      span_single = diff_wide[DATA_W] || (diff_wide == '0);
      smear       = diff_wide[DATA_W-1:0];
      smear       = smear | (smear >> 1);
      smear       = smear | (smear >> 2);
      smear       = smear | (smear >> 4);
      smear       = smear | (smear >> 8);
      smear       = smear | (smear >> 16);
   end

   // One generator step and the rejection test.
   always_comb begin
      gen_sum    = rd_a + rd_b;
      number     = {{(DATA_W - GEN_W){1'b0}}, gen_sum[WORD_W-1:OUT_SHIFT]} & mask_ff;
      hit        = (number <= diff_ff);
      last_try   = (try_ff == TRY_W'(MAX_TRIES - 1));
      half       = (mask_ff >> 1) + DATA_W'(1);
      pick       = hit ? number : (number - half);
      draw_value = lo_ff + pick;
   end

   // Ring port control.
   always_comb begin
      ring_wr.en   = 1'b0;
      ring_wr.addr = w_ff;
      ring_wr.data = gen_sum;
      ring_rd.addr_a = w_ff;
      ring_rd.addr_b = t_ff;
      case (state_ff)
         ST_FILL: begin
            ring_wr.en   = 1'b1;
            ring_wr.addr = fill_idx_ff;
            ring_wr.data = fill_word;
         end
         ST_STEP: begin
            ring_wr.en     = 1'b1;
            ring_rd.addr_a = idx_next(w_ff);
            ring_rd.addr_b = idx_next(t_ff);
         end
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      w_in        = w_ff;
      t_in        = t_ff;
      fill_idx_in = fill_idx_ff;
      prev1_in    = prev1_ff;
      prev2_in    = prev2_ff;
      seed_in     = seed_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      diff_in     = diff_ff;
      mask_in     = mask_ff;
      try_in      = try_ff;
      res_in      = res_ff;
      out_load    = 1'b0;
      out_data    = res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               seed_in     = req_seed_value;
               lo_in       = req_range_low;
               hi_in       = req_range_high;
               fill_idx_in = '0;
               try_in      = '0;
               state_in    = (req_kind == KIND_RESEED) ? ST_FILL : ST_SETUP;
            end
         end
         ST_FILL: begin
            prev2_in    = prev1_ff;
            prev1_in    = fill_word;
            fill_idx_in = fill_idx_ff + IDX_W'(1);
            if (fill_idx_ff == IDX_W'(RING_DEPTH - 1)) begin
               w_in     = '0;
               t_in     = IDX_W'(TAP_START);
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            diff_in = diff_wide[DATA_W-1:0];
            mask_in = smear;
            if (span_single) begin
               out_data = lo_ff;
               if (out_free) begin
                  out_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  res_in   = lo_ff;
                  state_in = ST_EMIT;
               end
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            w_in   = idx_next(w_ff);
            t_in   = idx_next(t_ff);
            try_in = try_ff + TRY_W'(1);
            if (hit || last_try) begin
               out_data = draw_value;
               if (out_free) begin
                  out_load = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  res_in   = draw_value;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = out_data;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         w_ff         <= '0;
         t_ff         <= IDX_W'(TAP_START);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         t_ff         <= t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      fill_idx_ff  <= fill_idx_in;
      prev1_ff     <= prev1_in;
      prev2_ff     <= prev2_in;
      seed_ff      <= seed_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      diff_ff      <= diff_in;
      mask_ff      <= mask_in;
      try_ff       <= try_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drawn_value = rsp_value_ff;

   // Expected tap index for the current write index.
   always_comb begin
      tap_sum = {1'b0, w_ff} + (IDX_W + 1)'(TAP_START);
      if (tap_sum >= (IDX_W + 1)'(RING_DEPTH)) begin
         tap_expect = IDX_W'(tap_sum - (IDX_W + 1)'(RING_DEPTH));
      end else begin
         tap_expect = tap_sum[IDX_W-1:0];
      end
   end

   // The tap index always trails the write index by the short lag.
   a_tap_lag: assert property (@(posedge clock) disable iff (reset)
      t_ff == tap_expect)
      else $error("tap index lost its lag behind the write index");

   // A finished reseed leaves the indices at their start positions.
   a_reseed_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) && (fill_idx_ff == IDX_W'(RING_DEPTH - 1))
      |=> (w_ff == '0) && (t_ff == IDX_W'(TAP_START)))
      else $error("reseed did not restore the ring indices");

   // A result for an ordered range lies inside that range.
   a_in_range: assert property (@(posedge clock) disable iff (reset)
      out_load && ($signed(lo_ff) <= $signed(hi_ff))
      |=> ($signed(rsp_value_ff) >= $signed(lo_ff))
          && ($signed(rsp_value_ff) <= $signed(hi_ff)))
      else $error("drawn value outside the requested range");

   // The input side is held off for the whole of a reseed.
   a_fill_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_kind == KIND_RESEED) |=> req_stall)
      else $error("request taken during reseed");

endmodule

`default_nettype wire

FILE: test/tb_lagged_fibonacci_range_draw.sv
`timescale 1ns / 1ps

module tb_lagged_fibonacci_range_draw;
   import lfrd_pkg::*;

   localparam int RANDOM_ITEMS   = 1330;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int REPORT_LIMIT   = 10;

   // One request as it travels over the input channel.
   typedef struct {
      logic                     kind;
      logic [WORD_W-1:0]        seed;
      logic signed [DATA_W-1:0] low;
      logic signed [DATA_W-1:0] high;
   } range_request_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_kind = KIND_DRAW;
   logic [WORD_W-1:0]        req_seed_value = '0;
   logic signed [DATA_W-1:0] req_range_low = '0;
   logic signed [DATA_W-1:0] req_range_high = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_drawn_value;

   // Shadow copy of the generator state.
   logic [WORD_W-1:0]        shadow_ring [RING_DEPTH];
   int                       shadow_write;
   int                       shadow_tap;

   range_request_type        pending_requests [$];
   range_request_type        current_request;
   logic signed [DATA_W-1:0] expected_draws [$];

   int total_requests = 0;
   int accepted_requests = 0;
   int reseed_count = 0;
   int draw_count = 0;
   int short_span_count = 0;
   int wide_span_count = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int gap_left = 0;
   int calm_items = 0;
   int stall_left = 0;
   int free_left = 0;
   int stall_roll;
   int idle_cycles = 0;

   lagged_fibonacci_range_draw u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_seed_value  (req_seed_value),
      .req_range_low   (req_range_low),
      .req_range_high  (req_range_high),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drawn_value (rsp_drawn_value)
   );

   always #10 clock = ~clock;

   // One generator step: add the tap word into the oldest word and advance both indices.
   function automatic logic [GEN_W-1:0] step_generator();
      logic [WORD_W-1:0] sum;
      sum = shadow_ring[shadow_write] + shadow_ring[shadow_tap];
      shadow_ring[shadow_write] = sum;
      shadow_write = (shadow_write == RING_DEPTH - 1) ? 0 : shadow_write + 1;
      shadow_tap = (shadow_tap == RING_DEPTH - 1) ? 0 : shadow_tap + 1;
      return sum[WORD_W-1:OUT_SHIFT];
   endfunction

   // Refill the ring as a Fibonacci sequence that starts with the seed and one.
   function automatic void reseed_ring(logic [WORD_W-1:0] seed);
      shadow_ring[0] = seed;
      shadow_ring[1] = WORD_W'(1);
      for (int i = 2; i < RING_DEPTH; i++) begin
         shadow_ring[i] = shadow_ring[i-1] + shadow_ring[i-2];
      end
      shadow_write = 0;
      shadow_tap = TAP_START;
   endfunction

   // Rejection sampling against a power-of-two mask, with the fallback after the last try.
   function automatic logic signed [DATA_W-1:0] predict_draw(
      logic signed [DATA_W-1:0] low,
      logic signed [DATA_W-1:0] high
   );
      longint span;
      longint power;
      longint number;
      span = longint'(high) - longint'(low) + 1;
      if (span <= 1) begin
         short_span_count++;
         return low;
      end
      if (span > (longint'(1) << GEN_W)) begin
         wide_span_count++;
      end
      power = 2;
      while (power < span) begin
         power = power << 1;
      end
      number = 0;
      for (int tries = 0; tries < MAX_TRIES; tries++) begin
         number = longint'(step_generator()) & (power - 1);
         if (number < span) begin
            break;
         end
      end
      if (number >= span) begin
         number = number - (power >> 1);
      end
      return DATA_W'(longint'(low) + number);
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm_items > 0) begin
         calm_items--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm_items = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   task automatic add_reseed(logic [WORD_W-1:0] seed);
      range_request_type item;
      item.kind = KIND_RESEED;
      item.seed = seed;
      item.low = $urandom;
      item.high = $urandom;
      pending_requests.push_back(item);
      total_requests++;
   endtask

   task automatic add_draw(logic signed [DATA_W-1:0] low, logic signed [DATA_W-1:0] high);
      range_request_type item;
      item.kind = KIND_DRAW;
      item.seed = WORD_W'($urandom);
      item.low = low;
      item.high = high;
      pending_requests.push_back(item);
      total_requests++;
   endtask

   task automatic add_span_draw(logic signed [DATA_W-1:0] low, longint span);
      add_draw(low, DATA_W'(longint'(low) + span - 1));
   endtask

   task automatic report_mismatch(string text);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, text);
      end
   endtask

   // Driver: present the next request, predict each one on its transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            accepted_requests++;
            if (current_request.kind == KIND_RESEED) begin
               reseed_ring(current_request.seed);
               reseed_count++;
            end else begin
               expected_draws.push_back(predict_draw(current_request.low,
                                                     current_request.high));
               draw_count++;
            end
         end
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               current_request = pending_requests.pop_front();
               req_kind <= current_request.kind;
               req_seed_value <= current_request.seed;
               req_range_low <= current_request.low;
               req_range_high <= current_request.high;
               req_valid <= 1'b1;
               gap_left = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest prediction, then pick the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_draws.size() == 0) begin
               report_mismatch($sformatf("Unexpected drawn_value %0d with no draw pending",
                                         rsp_drawn_value));
            end else begin
               checked_count++;
               if (rsp_drawn_value !== expected_draws[0]) begin
                  report_mismatch($sformatf("Result %0d: drawn_value expected %0d, got %0d",
                                            checked_count, expected_draws[0],
                                            rsp_drawn_value));
               end
               void'(expected_draws.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 60) begin
               rsp_stall <= 1'b0;
            end else if (stall_roll < 90) begin
               rsp_stall <= 1'b1;
               stall_left = $urandom_range(0, 2);
            end else if (stall_roll < 97) begin
               rsp_stall <= 1'b1;
               stall_left = $urandom_range(3, 11);
            end else if (stall_roll < 99) begin
               rsp_stall <= 1'b1;
               stall_left = $urandom_range(30, 80);
            end else begin
               rsp_stall <= 1'b0;
               free_left = $urandom_range(50, 200);
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d of %0d requests taken",
                  idle_cycles, accepted_requests, total_requests);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      int k;
      logic signed [DATA_W-1:0] low;
      longint span;

      for (int i = 0; i < RING_DEPTH; i++) begin
         shadow_ring[i] = '0;
      end
      shadow_write = 0;
      shadow_tap = TAP_START;

      // Draws on the unseeded ring, including the widest span and empty or single spans.
      add_draw(32'sh8000_0000, 32'sh7FFF_FFFF);
      add_draw(0, 9);
      add_draw(5, 5);
      add_draw(7, 3);
      add_draw(32'sh7FFF_FFFF, 32'sh8000_0000);
      // Smallest and largest seeds, spans around the 24-bit output width and the range edges.
      add_reseed('0);
      add_draw(0, 1);
      add_draw(32'sh8000_0000, 32'sh7FFF_FFFF);
      add_draw(-100, 100);
      add_reseed('1);
      add_draw(0, 32'sh00FF_FFFF);
      add_draw(0, 32'sh0100_0000);
      add_draw(32'sh8000_0000, 32'sh8000_0002);
      add_draw(32'sh7FFF_FFFC, 32'sh7FFF_FFFF);
      add_draw(0, 32'sh7FFF_FFFF);
      add_draw(32'sh8000_0000, -1);
      add_reseed(WORD_W'(12345));
      add_draw(1, 1000);
      add_draw(-3, -3);

      // Random mix: mostly draws of varied span shape, with occasional reseeds.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         low = $urandom;
         if (pick < 6) begin
            if (pick == 0) begin
               add_reseed('0);
            end else if (pick == 1) begin
               add_reseed('1);
            end else begin
               add_reseed(WORD_W'($urandom));
            end
         end else if (pick < 45) begin
            add_span_draw(low, longint'($urandom_range(2, 64)));
         end else if (pick < 60) begin
            k = $urandom_range(1, 32);
            span = (longint'(1) << k) + longint'(int'($urandom_range(0, 2)) - 1);
            add_span_draw(low, span);
         end else if (pick < 75) begin
            add_draw(low, $urandom);
         end else if (pick < 85) begin
            add_draw(low, DATA_W'(longint'(low) - longint'($urandom_range(0, 40))));
         end else begin
            span = longint'(1 << GEN_W) + 1 + longint'($urandom);
            add_span_draw(low, span);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every result to arrive, then let the block settle.
      while (accepted_requests < total_requests || expected_draws.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d reseeds and %0d draws; checked %0d drawn values.",
               reseed_count, draw_count, checked_count);
      $display("Draws with empty or single spans: %0d; spans wider than the output: %0d.",
               short_span_count, wide_span_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d failing checks in total", mismatch_count);
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/lfrd_pkg.sv
hw/rtl/lfrd_ring.sv
hw/rtl/lagged_fibonacci_range_draw.sv
test/tb_lagged_fibonacci_range_draw.sv
